[rtl/kst_pkg.sv]
package kst_pkg;

   localparam int VTX_BITS         = 6;
   localparam int WEIGHT_BITS      = 16;
   localparam int NV_BITS          = 7;
   localparam logic [NV_BITS-1:0] NV_RESET = 7'd64;
   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 256;

   typedef struct packed {
      logic [VTX_BITS-1:0]           edge_from;
      logic [VTX_BITS-1:0]           edge_to;
      logic signed [WEIGHT_BITS-1:0] edge_weight;
      logic                          last_edge;
   } req_type;

   typedef struct packed {
      logic [VTX_BITS-1:0]           tree_from;
      logic [VTX_BITS-1:0]           tree_to;
      logic signed [WEIGHT_BITS-1:0] tree_weight;
      logic                          is_edge;
      logic                          spanning;
      logic                          overflowed;
      logic                          last_result;
   } rsp_type;

   typedef struct packed {
      logic [VTX_BITS-1:0]           from;
      logic [VTX_BITS-1:0]           to;
      logic signed [WEIGHT_BITS-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic load;
      logic run_start;
      logic sweep_start;
      logic init_run;
      logic scan_start;
      logic scan_run;
      logic take_best;
      logic rd_a;
      logic rd_b;
      logic commit;
      logic merge_run;
      logic emit_start;
      logic rsp_load;
      logic emit_next;
      logic run_end;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic zero_target;
      logic scan_done;
      logic found;
      logic in_range;
      logic same;
      logic merge_done;
      logic full;
      logic emit_last;
   } sts_type;

endpackage

[rtl/kst_dpath.sv]
module kst_dpath
   import kst_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  req_type            req_data,
   input  logic               csr_valid,
   input  logic [NV_BITS-1:0] csr_data,
   output rsp_type            rsp_data
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int SW  = $clog2(MAX_VERTICES + 1);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int CW  = $clog2(MAX_EDGES + 1);

   logic [NV_BITS-1:0]     nv_ff;
   logic [NV_BITS-1:0]     nv_eff;
   logic [VW-1:0]          target;

   edge_type               edge_mem [MAX_EDGES];
   edge_type               edge_rd_ff;
   logic [CW-1:0]          count_ff;
   logic                   ovf_ff;

   logic [CW-1:0]          scan_idx_ff;
   logic                   rd_vld_ff;
   logic [EIW-1:0]         rd_idx_ff;
   logic                   found_ff;
   edge_type               best_ff;
   logic [EIW-1:0]         best_idx_ff;
   logic signed [WEIGHT_BITS-1:0] prev_w_ff;
   logic [EIW-1:0]         prev_idx_ff;
   logic                   have_prev_ff;
   logic                   cand;

   logic [VW-1:0]          label_mem [MAX_VERTICES];
   logic [VW-1:0]          lab_rd_ff;
   logic [VW-1:0]          lab_raddr;
   logic [SW-1:0]          sw_ff;
   logic                   mrg_vld_ff;
   logic [VW-1:0]          mrg_idx_ff;
   logic [VW-1:0]          la_ff;
   logic [VW-1:0]          lb_ff;

   edge_type               chosen_mem [MAX_VERTICES];
   edge_type               ch_rd_ff;
   logic [VW-1:0]          kept_ff;
   logic [VW-1:0]          emit_idx_ff;
   rsp_type                rsp_ff;

   always_comb begin
      nv_eff = nv_ff;
      if (nv_ff == '0) begin
         nv_eff = NV_BITS'(1);
      end else if (nv_ff > NV_BITS'(MAX_VERTICES)) begin
         nv_eff = NV_BITS'(MAX_VERTICES);
      end
      target = VW'(nv_eff - NV_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= NV_RESET;
      end else if (csr_valid) begin
         nv_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.run_end) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (count_ff < CW'(MAX_EDGES)) begin
            count_ff <= count_ff + CW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && count_ff < CW'(MAX_EDGES)) begin
         edge_mem[count_ff[EIW-1:0]] <= '{from: req_data.edge_from, to: req_data.edge_to,
                                         weight: req_data.edge_weight};
      end
      edge_rd_ff <= edge_mem[scan_idx_ff[EIW-1:0]];
   end

   assign cand = !have_prev_ff || (edge_rd_ff.weight > prev_w_ff) ||
                 (edge_rd_ff.weight == prev_w_ff && rd_idx_ff > prev_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         if (cmd.run_start) begin
            have_prev_ff <= 1'b0;
         end else if (cmd.take_best) begin
            have_prev_ff <= 1'b1;
         end
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            rd_vld_ff   <= 1'b0;
            found_ff    <= 1'b0;
         end else begin
            if (cmd.scan_run && scan_idx_ff < count_ff) begin
               scan_idx_ff <= scan_idx_ff + CW'(1);
               rd_vld_ff   <= 1'b1;
            end else begin
               rd_vld_ff <= 1'b0;
            end
            if (rd_vld_ff && cand && (!found_ff || edge_rd_ff.weight < best_ff.weight)) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff[EIW-1:0];
      if (!cmd.scan_start && rd_vld_ff && cand &&
          (!found_ff || edge_rd_ff.weight < best_ff.weight)) begin
         best_ff     <= edge_rd_ff;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.take_best) begin
         prev_w_ff   <= best_ff.weight;
         prev_idx_ff <= best_idx_ff;
      end
   end

   always_comb begin
      lab_raddr = sw_ff[VW-1:0];
      if (cmd.rd_a) begin
         lab_raddr = best_ff.from[VW-1:0];
      end else if (cmd.rd_b) begin
         lab_raddr = best_ff.to[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff      <= '0;
         mrg_vld_ff <= 1'b0;
      end else if (cmd.sweep_start) begin
         sw_ff      <= '0;
         mrg_vld_ff <= 1'b0;
      end else if (cmd.init_run) begin
         if (sw_ff < SW'(MAX_VERTICES)) begin
            sw_ff <= sw_ff + SW'(1);
         end
      end else if (cmd.merge_run && sw_ff < SW'(MAX_VERTICES)) begin
         sw_ff      <= sw_ff + SW'(1);
         mrg_vld_ff <= 1'b1;
      end else begin
         mrg_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_run && sw_ff < SW'(MAX_VERTICES)) begin
         label_mem[sw_ff[VW-1:0]] <= sw_ff[VW-1:0];
      end else if (mrg_vld_ff && lab_rd_ff == lb_ff) begin
         label_mem[mrg_idx_ff] <= la_ff;
      end
      lab_rd_ff  <= label_mem[lab_raddr];
      mrg_idx_ff <= sw_ff[VW-1:0];
      if (cmd.rd_b) begin
         la_ff <= lab_rd_ff;
      end
      if (cmd.commit) begin
         lb_ff <= lab_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff     <= '0;
         emit_idx_ff <= '0;
      end else begin
         if (cmd.run_start) begin
            kept_ff <= '0;
         end else if (cmd.commit) begin
            kept_ff <= kept_ff + VW'(1);
         end
         if (cmd.emit_start) begin
            emit_idx_ff <= '0;
         end else if (cmd.emit_next) begin
            emit_idx_ff <= emit_idx_ff + VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         chosen_mem[kept_ff] <= best_ff;
      end
      ch_rd_ff <= chosen_mem[emit_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.spanning    <= (kept_ff == target);
         rsp_ff.overflowed  <= ovf_ff;
         rsp_ff.last_result <= sts.emit_last;
         if (kept_ff == '0) begin
            rsp_ff.tree_from   <= '0;
            rsp_ff.tree_to     <= '0;
            rsp_ff.tree_weight <= '0;
            rsp_ff.is_edge     <= 1'b0;
         end else begin
            rsp_ff.tree_from   <= ch_rd_ff.from;
            rsp_ff.tree_to     <= ch_rd_ff.to;
            rsp_ff.tree_weight <= ch_rd_ff.weight;
            rsp_ff.is_edge     <= 1'b1;
         end
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      sts.init_done   = (sw_ff == SW'(MAX_VERTICES));
      sts.zero_target = (target == '0);
      sts.scan_done   = (scan_idx_ff == count_ff) && !rd_vld_ff;
      sts.found       = found_ff;
      sts.in_range    = ({1'b0, best_ff.from} < nv_eff) && ({1'b0, best_ff.to} < nv_eff);
      sts.same        = (la_ff == lab_rd_ff);
      sts.merge_done  = (sw_ff == SW'(MAX_VERTICES)) && !mrg_vld_ff;
      sts.full        = (kept_ff == target);
      sts.emit_last   = (kept_ff == '0) || (emit_idx_ff == VW'(kept_ff - VW'(1)));
   end

endmodule

[rtl/kst_ctrl.sv]
module kst_ctrl
   import kst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [3:0] S_LOAD       = 4'd0;
   localparam logic [3:0] S_INIT       = 4'd1;
   localparam logic [3:0] S_SCAN_START = 4'd2;
   localparam logic [3:0] S_SCAN       = 4'd3;
   localparam logic [3:0] S_CHECK      = 4'd4;
   localparam logic [3:0] S_RDA        = 4'd5;
   localparam logic [3:0] S_RDB        = 4'd6;
   localparam logic [3:0] S_CMP        = 4'd7;
   localparam logic [3:0] S_MERGE      = 4'd8;
   localparam logic [3:0] S_EMIT_RD    = 4'd9;
   localparam logic [3:0] S_EMIT_LD    = 4'd10;
   localparam logic [3:0] S_EMIT_WAIT  = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.run_start   = 1'b1;
                  cmd.sweep_start = 1'b1;
                  state_in        = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.init_run = 1'b1;
            if (sts.init_done) begin
               if (sts.zero_target) begin
                  cmd.emit_start = 1'b1;
                  state_in       = S_EMIT_RD;
               end else begin
                  state_in = S_SCAN_START;
               end
            end
         end
         S_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               if (sts.found) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.emit_start = 1'b1;
                  state_in       = S_EMIT_RD;
               end
            end
         end
         S_CHECK: begin
            cmd.take_best = 1'b1;
            state_in      = sts.in_range ? S_RDA : S_SCAN_START;
         end
         S_RDA: begin
            cmd.rd_a = 1'b1;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.rd_b = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sts.same) begin
               state_in = S_SCAN_START;
            end else begin
               cmd.commit      = 1'b1;
               cmd.sweep_start = 1'b1;
               state_in        = S_MERGE;
            end
         end
         S_MERGE: begin
            cmd.merge_run = 1'b1;
            if (sts.merge_done) begin
               if (sts.full) begin
                  cmd.emit_start = 1'b1;
                  state_in       = S_EMIT_RD;
               end else begin
                  state_in = S_SCAN_START;
               end
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (sts.emit_last) begin
                  cmd.run_end = 1'b1;
                  state_in    = S_LOAD;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in     = S_LOAD;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_only_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_EMIT_WAIT)
      else $error("result valid outside emit wait");

   a_no_load_during_emit: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("loading while result pending");

   a_last_returns_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_WAIT && rsp_ready && sts.emit_last) |=> state_ff == S_LOAD)
      else $error("run did not end after last result");

   a_commit_differs: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.same)
      else $error("edge kept inside one component");

endmodule

[rtl/kruskal_spanning_tree.sv]
// Kruskal minimum spanning tree. Edges load one item per cycle into an edge
// memory of MAX_EDGES entries; the item with last_edge set starts a run, during
// which req_ready is low. A run first sets up the component labels, then for
// each edge examined in weight order makes one pass over the edge memory
// (single read port) and checks its endpoints, relabels the components for
// each kept edge, and makes one closing pass when no edge is left.
// Results then leave one item at a time, each held until rsp_ready takes it.
// Writes on the csr port are taken every cycle and must only happen while idle.
module kruskal_spanning_tree
   import kst_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [NV_BITS-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_edge),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   kst_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
